// ===== sv/dwm_pkg.sv =====
// Shared types, codes and reset constants for the dual watermark usage monitor.
package dwm_pkg;

  typedef logic [1:0] level_t;
  typedef logic [1:0] trans_t;
  typedef logic [1:0] cmd_t;
  typedef logic [2:0] cfg_idx_t;

  localparam level_t LVL_NORMAL = 2'd0;
  localparam level_t LVL_HIGH   = 2'd1;
  localparam level_t LVL_FULL   = 2'd2;

  localparam trans_t TR_NONE = 2'd0;
  localparam trans_t TR_LOW  = 2'd1;
  localparam trans_t TR_HIGH = 2'd2;
  localparam trans_t TR_FULL = 2'd3;

  localparam cmd_t CMD_UPDATE = 2'd0;
  localparam cmd_t CMD_CLEAR  = 2'd1;
  localparam cmd_t CMD_REEVAL = 2'd2;

  localparam cfg_idx_t REG_BYTE_CAP  = 3'd0;
  localparam cfg_idx_t REG_BYTE_LOW  = 3'd1;
  localparam cfg_idx_t REG_BYTE_HIGH = 3'd2;
  localparam cfg_idx_t REG_MSG_CAP   = 3'd3;
  localparam cfg_idx_t REG_MSG_LOW   = 3'd4;
  localparam cfg_idx_t REG_MSG_HIGH  = 3'd5;

  localparam int BYTE_REG_W = 47;
  localparam int MSG_REG_W  = 31;
  localparam int CFG_DATA_W = 47;

  localparam logic [BYTE_REG_W-1:0] BYTE_CAP_RST  = 47'd1048576;
  localparam logic [BYTE_REG_W-1:0] BYTE_LOW_RST  = 47'd419430;
  localparam logic [BYTE_REG_W-1:0] BYTE_HIGH_RST = 47'd838860;
  localparam logic [MSG_REG_W-1:0]  MSG_CAP_RST   = 31'd1024;
  localparam logic [MSG_REG_W-1:0]  MSG_LOW_RST   = 31'd409;
  localparam logic [MSG_REG_W-1:0]  MSG_HIGH_RST  = 31'd819;

  localparam level_t BYTE_LVL_RST = (BYTE_CAP_RST == '0) ? LVL_FULL : LVL_NORMAL;
  localparam level_t MSG_LVL_RST  = (MSG_CAP_RST == '0) ? LVL_FULL : LVL_NORMAL;

  // direction of a count change
  typedef struct packed {
    logic up;
    logic down;
  } dir_t;

  // new level of one counter and the move it made
  typedef struct packed {
    level_t level;
    trans_t trans;
  } lvl_res_t;

  function automatic logic [1:0] max2(input logic [1:0] a, input logic [1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== sv/dual_watermark_usage_monitor_core.sv =====
// Top level of the dual watermark usage monitor: input stage, counters, result stage.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: update with signed
//   byte and message deltas, clear, or reevaluate after the marks have changed.
//   Output channel (out_valid/out_ready) returns exactly one result beat per input
//   beat: transition code, overall/byte/message levels and both running totals.
//   Configuration: cfg_write with cfg_index and cfg_data writes one watermark or
//   capacity register at once; write only while no beat is in flight.
//   Path: the input register loads when a beat is accepted; the counter update lands
//   in the result register when the beat moves on, which a held result can delay.
//   Throughput: one beat per cycle while results are taken; the counters and levels
//   are updated at the same edge at which a beat moves from the input register to the
//   result register, so the next beat sees them straight away.
//   Reset: counters go to zero, each level to normal (full for a zero capacity
//   reset value), registers to their defaults, both valids low.
//   Stall: a result not taken holds in the output register; one more beat may wait
//   in the input register, after which in_ready drops until out_ready returns.
module dual_watermark_usage_monitor_core #(
  parameter int BYTE_WIDTH = 48,
  parameter int MSG_WIDTH  = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  dwm_pkg::cfg_idx_t          cfg_index,
  input  logic [dwm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dwm_pkg::cmd_t              command,
  input  logic signed [47:0]         byte_delta,
  input  logic signed [31:0]         msg_delta,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dwm_pkg::trans_t            transition,
  output dwm_pkg::level_t            overall_level,
  output dwm_pkg::level_t            byte_level,
  output dwm_pkg::level_t            msg_level,
  output logic signed [47:0]         byte_total,
  output logic signed [31:0]         msg_total
);
  import dwm_pkg::*;

  // configuration registers
  logic [BYTE_REG_W-1:0] byte_cap;
  logic [BYTE_REG_W-1:0] byte_low;
  logic [BYTE_REG_W-1:0] byte_high;
  logic [MSG_REG_W-1:0]  msg_cap;
  logic [MSG_REG_W-1:0]  msg_low;
  logic [MSG_REG_W-1:0]  msg_high;

  // input stage
  logic               s1_valid;
  cmd_t               s1_command;
  logic signed [47:0] s1_byte_delta;
  logic signed [31:0] s1_msg_delta;

  // counter state
  logic [BYTE_WIDTH-1:0] byte_count;
  logic [MSG_WIDTH-1:0]  msg_count;
  level_t                byte_state;
  level_t                msg_state;

  logic                  advance;
  logic                  is_reeval;
  logic signed [63:0]    bd_wide;
  logic signed [63:0]    md_wide;
  logic [BYTE_WIDTH-1:0] b_base;
  logic [BYTE_WIDTH-1:0] b_delta;
  logic [MSG_WIDTH-1:0]  m_base;
  logic [MSG_WIDTH-1:0]  m_delta;
  dir_t                  b_dir;
  dir_t                  m_dir;
  level_t                b_lvl_in;
  level_t                m_lvl_in;
  logic [BYTE_WIDTH-1:0] b_sum;
  logic [MSG_WIDTH-1:0]  m_sum;
  lvl_res_t              b_res;
  lvl_res_t              m_res;
  level_t                overall_now;

  logic [BYTE_WIDTH-1:0] byte_count_next;
  logic [MSG_WIDTH-1:0]  msg_count_next;
  level_t                byte_state_next;
  level_t                msg_state_next;
  trans_t                transition_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cap  <= BYTE_CAP_RST;
      byte_low  <= BYTE_LOW_RST;
      byte_high <= BYTE_HIGH_RST;
      msg_cap   <= MSG_CAP_RST;
      msg_low   <= MSG_LOW_RST;
      msg_high  <= MSG_HIGH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BYTE_CAP:  byte_cap  <= cfg_data;
        REG_BYTE_LOW:  byte_low  <= cfg_data;
        REG_BYTE_HIGH: byte_high <= cfg_data;
        REG_MSG_CAP:   msg_cap   <= cfg_data[MSG_REG_W-1:0];
        REG_MSG_LOW:   msg_low   <= cfg_data[MSG_REG_W-1:0];
        REG_MSG_HIGH:  msg_high  <= cfg_data[MSG_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command    <= command;
      s1_byte_delta <= byte_delta;
      s1_msg_delta  <= msg_delta;
    end
  end

  // reevaluate replays the old count onto a zero counter from normal
  assign is_reeval = (s1_command == CMD_REEVAL);
  assign bd_wide   = 64'(s1_byte_delta);
  assign md_wide   = 64'(s1_msg_delta);

  always_comb begin
    if (is_reeval) begin
      b_base   = '0;
      b_delta  = byte_count;
      b_dir.up = (byte_count != '0) && !byte_count[BYTE_WIDTH-1];
      b_dir.down = byte_count[BYTE_WIDTH-1];
      b_lvl_in = LVL_NORMAL;
      m_base   = '0;
      m_delta  = msg_count;
      m_dir.up = (msg_count != '0) && !msg_count[MSG_WIDTH-1];
      m_dir.down = msg_count[MSG_WIDTH-1];
      m_lvl_in = LVL_NORMAL;
    end else begin
      b_base   = byte_count;
      b_delta  = bd_wide[BYTE_WIDTH-1:0];
      b_dir.up = (s1_byte_delta != '0) && !s1_byte_delta[47];
      b_dir.down = s1_byte_delta[47];
      b_lvl_in = byte_state;
      m_base   = msg_count;
      m_delta  = md_wide[MSG_WIDTH-1:0];
      m_dir.up = (s1_msg_delta != '0) && !s1_msg_delta[31];
      m_dir.down = s1_msg_delta[31];
      m_lvl_in = msg_state;
    end
  end

  dwm_level #(.CW(BYTE_WIDTH), .RW(BYTE_REG_W)) u_byte_level (
    .level_in  (b_lvl_in),
    .base      (b_base),
    .delta     (b_delta),
    .dir       (b_dir),
    .cap       (byte_cap),
    .low_mark  (byte_low),
    .high_mark (byte_high),
    .count_next(b_sum),
    .res       (b_res)
  );

  dwm_level #(.CW(MSG_WIDTH), .RW(MSG_REG_W)) u_msg_level (
    .level_in  (m_lvl_in),
    .base      (m_base),
    .delta     (m_delta),
    .dir       (m_dir),
    .cap       (msg_cap),
    .low_mark  (msg_low),
    .high_mark (msg_high),
    .count_next(m_sum),
    .res       (m_res)
  );

  assign overall_now = max2(byte_state, msg_state);

  always_comb begin
    byte_count_next = byte_count;
    msg_count_next  = msg_count;
    byte_state_next = byte_state;
    msg_state_next  = msg_state;
    transition_next = TR_NONE;
    case (s1_command)
      CMD_UPDATE: begin
        byte_count_next = b_sum;
        msg_count_next  = m_sum;
        byte_state_next = b_res.level;
        msg_state_next  = m_res.level;
        if (max2(b_res.level, m_res.level) != overall_now) begin
          transition_next = max2(b_res.trans, m_res.trans);
        end
      end
      CMD_CLEAR: begin
        byte_count_next = '0;
        msg_count_next  = '0;
        byte_state_next = LVL_NORMAL;
        msg_state_next  = LVL_NORMAL;
      end
      CMD_REEVAL: begin
        byte_count_next = b_sum;
        msg_count_next  = m_sum;
        byte_state_next = (byte_cap == '0) ? LVL_FULL : b_res.level;
        msg_state_next  = (msg_cap == '0) ? LVL_FULL : m_res.level;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      msg_count  <= '0;
      byte_state <= BYTE_LVL_RST;
      msg_state  <= MSG_LVL_RST;
    end else if (advance) begin
      byte_count <= byte_count_next;
      msg_count  <= msg_count_next;
      byte_state <= byte_state_next;
      msg_state  <= msg_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload: totals are sign-extended or truncated to the port widths
  always_ff @(posedge clk) begin
    if (advance) begin
      transition    <= transition_next;
      overall_level <= max2(byte_state_next, msg_state_next);
      byte_level    <= byte_state_next;
      msg_level     <= msg_state_next;
      byte_total    <= 48'($signed(byte_count_next));
      msg_total     <= 32'($signed(msg_count_next));
    end
  end

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    advance && s1_command == CMD_CLEAR |=>
      out_valid && byte_total == '0 && msg_total == '0 && overall_level == LVL_NORMAL)
    else $error("clear did not zero the counters");

  a_trans_needs_change: assert property (@(posedge clk) disable iff (rst)
    advance |=> transition == TR_NONE || overall_level != $past(overall_now))
    else $error("transition reported without a change of overall level");

  a_full_trans_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && transition == TR_FULL |-> overall_level == LVL_FULL)
    else $error("full transition with overall level not full");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_command) && $stable(s1_byte_delta))
    else $error("waiting input beat lost");

  a_result_from_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result valid without an advancing beat");

endmodule

// ===== sv/dwm_level.sv =====
// One occupancy counter: add, compare against the marks and step the hysteresis level.
module dwm_level #(
  parameter int CW = 48,
  parameter int RW = 47
) (
  input  dwm_pkg::level_t   level_in,
  input  logic [CW-1:0]     base,
  input  logic [CW-1:0]     delta,
  input  dwm_pkg::dir_t     dir,
  input  logic [RW-1:0]     cap,
  input  logic [RW-1:0]     low_mark,
  input  logic [RW-1:0]     high_mark,
  output logic [CW-1:0]     count_next,
  output dwm_pkg::lvl_res_t res
);
  import dwm_pkg::*;

  localparam int CMPW = ((CW > RW) ? CW : RW) + 1;

  logic signed [CMPW-1:0] vx;
  logic signed [CMPW-1:0] capx;
  logic signed [CMPW-1:0] lowx;
  logic signed [CMPW-1:0] highx;
  logic                   ge_cap;
  logic                   ge_high;
  logic                   le_high;
  logic                   le_low;

  assign count_next = base + delta;
  assign vx    = {{(CMPW-CW){count_next[CW-1]}}, count_next};
  assign capx  = {{(CMPW-RW){1'b0}}, cap};
  assign lowx  = {{(CMPW-RW){1'b0}}, low_mark};
  assign highx = {{(CMPW-RW){1'b0}}, high_mark};

  assign ge_cap  = (vx >= capx);
  assign ge_high = (vx >= highx);
  assign le_high = (highx >= vx);
  assign le_low  = (lowx >= vx);

  always_comb begin
    res.level = level_in;
    res.trans = TR_NONE;
    if (dir.up) begin
      // both steps may fire in one beat
      if (res.level == LVL_NORMAL && ge_high) begin
        res.level = LVL_HIGH;
        res.trans = TR_HIGH;
      end
      if (res.level == LVL_HIGH && ge_cap) begin
        res.level = LVL_FULL;
        res.trans = TR_FULL;
      end
    end else if (dir.down && cap != '0) begin
      if (res.level == LVL_FULL && le_high) begin
        res.level = LVL_HIGH;
      end
      if (res.level == LVL_HIGH && le_low) begin
        res.level = LVL_NORMAL;
        res.trans = TR_LOW;
      end
    end
  end

endmodule

// ===== test/dual_watermark_usage_monitor_core_tb.sv =====
// Self-checking testbench for the dual watermark usage monitor core.
`timescale 1ns / 1ps

module dual_watermark_usage_monitor_core_tb;
  import dwm_pkg::*;

  localparam cmd_t CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [46:0] BYTE_MAX = '1;
  localparam logic [30:0] MSG_MAX = '1;

  typedef struct packed {
    cmd_t        cmd;
    logic [47:0] bd;
    logic [31:0] md;
  } beat_t;

  typedef struct packed {
    trans_t      tr;
    level_t      all_lv;
    level_t      b_lv;
    level_t      m_lv;
    logic [47:0] b_tot;
    logic [31:0] m_tot;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  cfg_idx_t cfg_index = REG_BYTE_CAP;
  logic [46:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  cmd_t command = CMD_UPDATE;
  logic signed [47:0] byte_delta = '0;
  logic signed [31:0] msg_delta = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  trans_t transition;
  level_t overall_level;
  level_t byte_level;
  level_t msg_level;
  logic signed [47:0] byte_total;
  logic signed [31:0] msg_total;

  dual_watermark_usage_monitor_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .byte_delta(byte_delta),
    .msg_delta(msg_delta),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .transition(transition),
    .overall_level(overall_level),
    .byte_level(byte_level),
    .msg_level(msg_level),
    .byte_total(byte_total),
    .msg_total(msg_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's registers and counters
  logic [46:0] m_bcap = BYTE_CAP_RST;
  logic [46:0] m_blow = BYTE_LOW_RST;
  logic [46:0] m_bhigh = BYTE_HIGH_RST;
  logic [30:0] m_mcap = MSG_CAP_RST;
  logic [30:0] m_mlow = MSG_LOW_RST;
  logic [30:0] m_mhigh = MSG_HIGH_RST;
  logic signed [47:0] m_bytes = '0;
  logic signed [31:0] m_msgs = '0;
  level_t m_blvl = BYTE_LVL_RST;
  level_t m_mlvl = MSG_LVL_RST;

  beat_t beat_queue[$];
  status_t pending_status[$];
  longint byte_span = 350000;
  longint msg_span = 350;
  int mismatches = 0;
  int status_seen = 0;
  int cycles = 0;
  logic took = 1'b0;

  function automatic level_t worse(level_t a, level_t b);
    return (a > b) ? a : b;
  endfunction

  // Hysteresis step of one counter; cnt is the count after the delta
  function automatic lvl_res_t next_level(level_t lvl, longint cnt, longint delta,
                                          longint cap, longint lo, longint hi);
    lvl_res_t r;
    r.level = lvl;
    r.trans = TR_NONE;
    if (delta > 0) begin
      if (r.level == LVL_NORMAL && cnt >= hi) begin
        r.level = LVL_HIGH;
        r.trans = TR_HIGH;
      end
      if (r.level == LVL_HIGH && cnt >= cap) begin
        r.level = LVL_FULL;
        r.trans = TR_FULL;
      end
    end else if (delta < 0 && cap != 0) begin
      if (r.level == LVL_FULL && cnt <= hi) r.level = LVL_HIGH;
      if (r.level == LVL_HIGH && cnt <= lo) begin
        r.level = LVL_NORMAL;
        r.trans = TR_LOW;
      end
    end
    return r;
  endfunction

  function automatic trans_t advance_counts(logic signed [47:0] bd, logic signed [31:0] md);
    level_t was;
    lvl_res_t br;
    lvl_res_t mr;
    was = worse(m_blvl, m_mlvl);
    m_bytes = m_bytes + bd;
    m_msgs = m_msgs + md;
    br = next_level(m_blvl, longint'(m_bytes), longint'(bd), longint'(m_bcap),
                    longint'(m_blow), longint'(m_bhigh));
    mr = next_level(m_mlvl, longint'(m_msgs), longint'(md), longint'(m_mcap),
                    longint'(m_mlow), longint'(m_mhigh));
    m_blvl = br.level;
    m_mlvl = mr.level;
    if (worse(m_blvl, m_mlvl) == was) return TR_NONE;
    return (br.trans > mr.trans) ? br.trans : mr.trans;
  endfunction

  function automatic status_t step_monitor(beat_t b);
    status_t s;
    logic signed [47:0] ob;
    logic signed [31:0] om;
    s.tr = TR_NONE;
    case (b.cmd)
      CMD_UPDATE: s.tr = advance_counts(b.bd, b.md);
      CMD_CLEAR: begin
        m_bytes = '0;
        m_msgs = '0;
        m_blvl = LVL_NORMAL;
        m_mlvl = LVL_NORMAL;
      end
      CMD_REEVAL: begin
        // replay the old counts from empty, then force zero capacities full
        ob = m_bytes;
        om = m_msgs;
        m_bytes = '0;
        m_msgs = '0;
        m_blvl = LVL_NORMAL;
        m_mlvl = LVL_NORMAL;
        void'(advance_counts(ob, om));
        if (m_bcap == '0) m_blvl = LVL_FULL;
        if (m_mcap == '0) m_mlvl = LVL_FULL;
      end
      default: ;
    endcase
    s.all_lv = worse(m_blvl, m_mlvl);
    s.b_lv = m_blvl;
    s.m_lv = m_mlvl;
    s.b_tot = m_bytes;
    s.m_tot = m_msgs;
    return s;
  endfunction

  function automatic void queue_beat(cmd_t c, logic [47:0] b, logic [31:0] m);
    beat_t x;
    x.cmd = c;
    x.bd = b;
    x.md = m;
    beat_queue.push_back(x);
  endfunction

  // Upward-biased step so the counters climb through the marks between clears
  function automatic longint rand_span(longint span);
    longint unsigned u;
    longint down;
    u = {$urandom, $urandom};
    down = span / 2;
    return longint'(u % longint'(span + down + 1)) - down;
  endfunction

  function automatic void queue_random(int n);
    beat_t b;
    int pick;
    logic [63:0] wide;
    longint r;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 84) b.cmd = CMD_UPDATE;
      else if (pick < 90) b.cmd = CMD_CLEAR;
      else if (pick < 97) b.cmd = CMD_REEVAL;
      else b.cmd = CMD_UNUSED;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        wide = {$urandom, $urandom};
        b.bd = wide[47:0];
        b.md = wide[63:32];
      end else begin
        r = rand_span(byte_span);
        b.bd = r[47:0];
        r = rand_span(msg_span);
        b.md = r[31:0];
        if (pick == 1) b.bd = '0;
        if (pick == 2) b.md = '0;
      end
      beat_queue.push_back(b);
    end
  endfunction

  task automatic drain();
    while (beat_queue.size() != 0 || pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [46:0] bcap, input logic [46:0] blow,
                           input logic [46:0] bhigh, input logic [30:0] mcap,
                           input logic [30:0] mlow, input logic [30:0] mhigh);
    logic [31:0] junk;
    logic [46:0] big;
    logic [30:0] mbig;
    drain();
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      junk = $urandom;
      cfg_write <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      // message registers ignore the upper data bits; fill them with noise
      case (cfg_idx_t'(i))
        REG_BYTE_CAP: begin
          cfg_data <= bcap;
          m_bcap = bcap;
        end
        REG_BYTE_LOW: begin
          cfg_data <= blow;
          m_blow = blow;
        end
        REG_BYTE_HIGH: begin
          cfg_data <= bhigh;
          m_bhigh = bhigh;
        end
        REG_MSG_CAP: begin
          cfg_data <= {junk[15:0], mcap};
          m_mcap = mcap;
        end
        REG_MSG_LOW: begin
          cfg_data <= {junk[15:0], mlow};
          m_mlow = mlow;
        end
        default: begin
          cfg_data <= {junk[15:0], mhigh};
          m_mhigh = mhigh;
        end
      endcase
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    big = bcap;
    if (bhigh > big) big = bhigh;
    if (blow > big) big = blow;
    mbig = mcap;
    if (mhigh > mbig) mbig = mhigh;
    if (mlow > mbig) mbig = mlow;
    byte_span = longint'(big) / 3 + 50;
    msg_span = longint'(mbig) / 3 + 50;
  endtask

  // Input side: record accepted beats and predict their status
  always @(posedge clk) begin
    took <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      pending_status.push_back(step_monitor(beat_queue.pop_front()));
    end
  end

  // Driver: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (beat_queue.size() > 0) begin
        in_valid <= 1'b1;
        command <= beat_queue[0].cmd;
        byte_delta <= beat_queue[0].bd;
        msg_delta <= beat_queue[0].md;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: rotating stall pattern plus two long hold-offs
  int rx_tick = 0;
  int hold_left = 0;
  int holds_done = 0;
  always @(negedge clk) begin
    rx_tick++;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < 2 && status_seen >= ((holds_done == 0) ? 610 : 1490)) begin
      holds_done++;
      hold_left = 300;
      out_ready <= 1'b0;
    end else begin
      case ((rx_tick >> 7) & 3)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) < 7);
        2: out_ready <= ((rx_tick & 2) != 0) ^ ((rx_tick & 8) != 0);
        default: out_ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    status_t want;
    if (!rst && out_valid && out_ready) begin
      status_seen++;
      if (pending_status.size() == 0) begin
        $error("result beat with no prediction waiting");
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        if (transition !== want.tr) begin
          $error("transition: expected %0d, got %0d", want.tr, transition);
          mismatches++;
        end
        if (overall_level !== want.all_lv) begin
          $error("overall_level: expected %0d, got %0d", want.all_lv, overall_level);
          mismatches++;
        end
        if (byte_level !== want.b_lv) begin
          $error("byte_level: expected %0d, got %0d", want.b_lv, byte_level);
          mismatches++;
        end
        if (msg_level !== want.m_lv) begin
          $error("msg_level: expected %0d, got %0d", want.m_lv, msg_level);
          mismatches++;
        end
        if (byte_total !== want.b_tot) begin
          $error("byte_total: expected %0d, got %0d", $signed(want.b_tot), byte_total);
          mismatches++;
        end
        if (msg_total !== want.m_tot) begin
          $error("msg_total: expected %0d, got %0d", $signed(want.m_tot), msg_total);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // Default marks: rise through high and full, fall back, wrap, all commands
    queue_beat(CMD_UPDATE, 48'd0, 32'd0);
    queue_beat(CMD_UPDATE, 48'd838860, 32'd0);
    queue_beat(CMD_UPDATE, 48'd209716, 32'd0);
    queue_beat(CMD_UPDATE, -48'sd209716, 32'd0);
    queue_beat(CMD_UPDATE, -48'sd838860, 32'd0);
    queue_beat(CMD_UPDATE, 48'd0, 32'd1024);
    queue_beat(CMD_UPDATE, 48'd5, -32'sd1);
    queue_beat(CMD_CLEAR, 48'd0, 32'd0);
    queue_beat(CMD_UPDATE, 48'd1, 32'd800);
    queue_beat(CMD_REEVAL, 48'd0, 32'd0);
    queue_beat(CMD_UNUSED, 48'hA5A5_A5A5_A5A5, 32'h5A5A_5A5A);
    queue_beat(CMD_UPDATE, 48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF);
    queue_beat(CMD_UPDATE, 48'd1, 32'd1);
    queue_beat(CMD_UPDATE, 48'h8000_0000_0000, 32'h8000_0000);
    queue_beat(CMD_REEVAL, 48'd0, 32'd0);
    queue_beat(CMD_CLEAR, 48'd0, 32'd0);
    queue_beat(CMD_UPDATE, -48'sd5, -32'sd5);
    queue_beat(CMD_REEVAL, 48'd0, 32'd0);
    queue_beat(CMD_UPDATE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero capacities with the marks crossed over
    configure(47'd0, 47'd100, 47'd50, 31'd0, 31'd30, 31'd10);
    queue_beat(CMD_REEVAL, 48'd0, 32'd0);
    queue_beat(CMD_UPDATE, -48'sd7, -32'sd7);
    queue_beat(CMD_CLEAR, 48'd0, 32'd0);
    queue_beat(CMD_UPDATE, 48'd60, 32'd20);
    queue_beat(CMD_UPDATE, -48'sd200, -32'sd200);
    queue_beat(CMD_REEVAL, 48'd0, 32'd0);

    configure(47'd1000, 47'd200, 47'd600, 31'd64, 31'd16, 31'd48);
    queue_random(280);
    configure(BYTE_MAX, 47'd0, BYTE_MAX, MSG_MAX, 31'd0, MSG_MAX);
    queue_random(250);
    configure(47'd0, 47'd0, 47'd0, 31'd0, 31'd0, 31'd0);
    queue_random(250);
    configure(47'($urandom_range(0, 3000)), 47'($urandom_range(0, 3000)),
              47'($urandom_range(0, 3000)), 31'($urandom_range(0, 200)),
              31'($urandom_range(0, 200)), 31'($urandom_range(0, 200)));
    queue_random(300);
    configure(47'd1, 47'd0, 47'd1, 31'd1, 31'd0, 31'd0);
    queue_random(250);
    configure(BYTE_CAP_RST, BYTE_LOW_RST, BYTE_HIGH_RST, MSG_CAP_RST, MSG_LOW_RST,
              MSG_HIGH_RST);
    queue_random(300);
    configure(47'($urandom_range(0, 3000)), 47'($urandom_range(0, 3000)),
              47'($urandom_range(0, 3000)), 31'($urandom_range(0, 200)),
              31'($urandom_range(0, 200)), 31'($urandom_range(0, 200)));
    queue_random(320);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
